// ===== src/hebrew_year_and_month_length_unit_assert.svh =====
// Assertion macros for the year/month length unit.
// Both expect signals named clk and rst in the scope of use.
`ifndef HEBREW_YEAR_AND_MONTH_LENGTH_UNIT_ASSERT_SVH
`define HEBREW_YEAR_AND_MONTH_LENGTH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HYML_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HYML_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hyml_pkg.sv =====
`default_nettype none

package hyml_pkg;

  // Field widths
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int MCOUNT_W    = 4;
  localparam int MLEN_W      = 5;
  localparam int YLEN_W      = 9;
  localparam int ELAPSED_W   = 22;

  // Pipeline shape
  localparam int NUM_LANES   = 4;
  localparam int LANE_STAGES = 5;
  localparam int FIN_STAGES  = 2;
  localparam int NUM_STAGES  = LANE_STAGES + FIN_STAGES;

  // Internal widths
  localparam int LANE_Y_W    = 15;  // year + 1, up to 16386
  localparam int LEAP_X_W    = 17;  // 7*y + small constant
  localparam int Q19_W       = 13;
  localparam int MEAN_MON_W  = 18;  // biased month count
  localparam int PARTS_W     = 32;
  localparam int PARTS_SHIFT = 6;   // 25920 = 64 * 405
  localparam int PARTS_HI_W  = PARTS_W - PARTS_SHIFT;
  localparam int PDAY_W      = 17;
  localparam int DAYS_W      = 23;  // biased day count

  // Exact reciprocal multipliers
  localparam logic [17:0] DIV19_MUL    = 18'd220753;
  localparam int          DIV19_SHIFT  = 22;
  localparam logic [26:0] DIV405_MUL   = 27'd84838861;
  localparam int          DIV405_SHIFT = 35;
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int          DIV10_SHIFT  = 11;
  localparam int          DIV10_Q_W    = 6;

  // Calendar constants
  localparam logic [4:0]  CYCLE_YEARS     = 5'd19;
  localparam logic [2:0]  LEAP_STEP       = 3'd7;
  localparam logic [3:0]  MONTHS_BASE     = 4'd12;
  localparam logic [13:0] PARTS_PER_MONTH = 14'd13753;
  localparam logic [12:0] PARTS_BIAS      = 13'd5219;  // 12084 shifted by the month bias
  localparam logic [4:0]  MONTH_DAYS      = 5'd29;
  localparam logic [9:0]  DAY_BIAS        = 10'd738;
  localparam logic [2:0]  WEEK_BIAS       = 3'd5;
  localparam logic [8:0]  LEN_POSTPONE2   = 9'd356;
  localparam logic [8:0]  LEN_POSTPONE1   = 9'd382;

  localparam logic [MCOUNT_W-1:0] MONTHS_COMMON = 4'd12;
  localparam logic [MCOUNT_W-1:0] MONTHS_LEAP   = 4'd13;
  localparam logic [MLEN_W-1:0]   DAYS_SHORT    = 5'd29;
  localparam logic [MLEN_W-1:0]   DAYS_FULL     = 5'd30;

  typedef struct packed {
    logic [FIN_STAGES-1:0]  fin_en;
    logic [LANE_STAGES-1:0] lane_en;
  } hyml_ctl_t;

  typedef struct packed {
    logic               leap;
    logic [MONTH_W-1:0] month;
  } hyml_side_t;

endpackage

`default_nettype wire

// ===== src/hyml_if.sv =====
`default_nettype none

interface hyml_req_if;
  logic                          valid;
  logic                          ready;
  logic [hyml_pkg::YEAR_W-1:0]   hebrew_year;
  logic [hyml_pkg::MONTH_W-1:0]  month_number;

  modport source (output valid, hebrew_year, month_number, input ready);
  modport sink   (input valid, hebrew_year, month_number, output ready);
endinterface

interface hyml_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            leap_flag;
  logic [hyml_pkg::MCOUNT_W-1:0]   months_in_year;
  logic [hyml_pkg::MLEN_W-1:0]     month_length;
  logic [hyml_pkg::YLEN_W-1:0]     year_length;
  logic [hyml_pkg::ELAPSED_W-1:0]  new_year_elapsed;

  modport source (output valid, leap_flag, months_in_year, month_length, year_length,
                  new_year_elapsed, input ready);
  modport sink   (input valid, leap_flag, months_in_year, month_length, year_length,
                  new_year_elapsed, output ready);
endinterface

`default_nettype wire

// ===== src/hyml_ctrl.sv =====
`default_nettype none

module hyml_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output hyml_pkg::hyml_ctl_t  ctl
);

  logic [hyml_pkg::NUM_STAGES-1:0] vld;
  logic [hyml_pkg::NUM_STAGES-1:0] en;

  // A stage loads when it is empty or its occupant moves on this cycle.
  always_comb begin
    en[hyml_pkg::NUM_STAGES-1] = !vld[hyml_pkg::NUM_STAGES-1] || out_ready;
    for (int k = hyml_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < hyml_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    ctl.lane_en = en[hyml_pkg::LANE_STAGES-1:0];
    ctl.fin_en  = en[hyml_pkg::NUM_STAGES-1:hyml_pkg::LANE_STAGES];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[hyml_pkg::NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== src/hyml_lane.sv =====
`default_nettype none

// Mean molad day count with weekday postponement for one year.
// year_p1 is the evaluated year plus one; days is the count plus DAY_BIAS.
module hyml_lane (
  input  wire                                clk,
  input  wire hyml_pkg::hyml_ctl_t           ctl,
  input  wire [hyml_pkg::LANE_Y_W-1:0]       year_p1,
  output logic [hyml_pkg::DAYS_W-1:0]        days
);

  // Octal digit sum, 8 == 1 mod 7.
  function automatic logic [2:0] mod7(input logic [hyml_pkg::DAYS_W-1:0] x);
    logic [hyml_pkg::DAYS_W:0] xp;
    logic [5:0]                s1;
    logic [3:0]                s2;
    xp = {1'b0, x};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(xp[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    mod7 = (s2 >= 4'(hyml_pkg::LEAP_STEP)) ? 3'(s2 - 4'(hyml_pkg::LEAP_STEP)) : s2[2:0];
  endfunction

  // Stage 1: quotient of (7*y1 + 6) / 19
  logic [hyml_pkg::LEAP_X_W-1:0]         a_val;
  logic [hyml_pkg::LEAP_X_W+17:0]        a_prod;
  logic [hyml_pkg::LANE_Y_W-1:0]         s1_y;
  logic [hyml_pkg::Q19_W-1:0]            s1_q19;

  assign a_val  = 17'(year_p1) * 17'(hyml_pkg::LEAP_STEP) + 17'd6;
  assign a_prod = 35'(a_val) * 35'(hyml_pkg::DIV19_MUL);

  always_ff @(posedge clk) begin
    if (ctl.lane_en[0]) begin
      s1_y   <= year_p1;
      s1_q19 <= a_prod[hyml_pkg::DIV19_SHIFT +: hyml_pkg::Q19_W];
    end
  end

  // Stage 2: biased month count and parts
  logic [hyml_pkg::MEAN_MON_W-1:0]  mon;
  logic [hyml_pkg::PARTS_W-1:0]     parts;
  logic [hyml_pkg::MEAN_MON_W-1:0]  s2_mon;
  logic [hyml_pkg::PARTS_HI_W-1:0]  s2_ph;

  assign mon   = 18'(s1_y) * 18'(hyml_pkg::MONTHS_BASE) + 18'(s1_q19);
  assign parts = 32'(mon) * 32'(hyml_pkg::PARTS_PER_MONTH) + 32'(hyml_pkg::PARTS_BIAS);

  always_ff @(posedge clk) begin
    if (ctl.lane_en[1]) begin
      s2_mon <= mon;
      s2_ph  <= parts[hyml_pkg::PARTS_SHIFT +: hyml_pkg::PARTS_HI_W];
    end
  end

  // Stage 3: whole days from parts, / 405 after the shift by 64
  logic [hyml_pkg::PARTS_HI_W+26:0]  q_prod;
  logic [hyml_pkg::MEAN_MON_W-1:0]   s3_mon;
  logic [hyml_pkg::PDAY_W-1:0]       s3_q;

  assign q_prod = 53'(s2_ph) * 53'(hyml_pkg::DIV405_MUL);

  always_ff @(posedge clk) begin
    if (ctl.lane_en[2]) begin
      s3_mon <= s2_mon;
      s3_q   <= q_prod[hyml_pkg::DIV405_SHIFT +: hyml_pkg::PDAY_W];
    end
  end

  // Stage 4: day count before postponement
  logic [hyml_pkg::DAYS_W-1:0] s4_d;

  always_ff @(posedge clk) begin
    if (ctl.lane_en[3]) begin
      s4_d <= 23'(s3_mon) * 23'(hyml_pkg::MONTH_DAYS) + 23'(s3_q);
    end
  end

  // Stage 5: postpone when 3*(days+1) mod 7 < 3, i.e. (days+1) mod 7 is 0, 3 or 5
  logic [2:0] wd;
  logic       post;

  assign wd = mod7(s4_d + 23'(hyml_pkg::WEEK_BIAS));

  always_comb begin
    case (wd)
      3'd0, 3'd3, 3'd5: post = 1'b1;
      default:          post = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.lane_en[4]) begin
      days <= s4_d + 23'(post);
    end
  end

endmodule

`default_nettype wire

// ===== src/hyml_finish.sv =====
`default_nettype none

// Adjacent-year delays, year length, month length and output register.
module hyml_finish (
  input  wire                                                   clk,
  input  wire hyml_pkg::hyml_ctl_t                              ctl,
  input  wire [hyml_pkg::NUM_LANES-1:0][hyml_pkg::DAYS_W-1:0]   days,
  input  wire hyml_pkg::hyml_side_t                             side,
  output logic                                                  leap_flag,
  output logic [hyml_pkg::MCOUNT_W-1:0]                         months_in_year,
  output logic [hyml_pkg::MLEN_W-1:0]                           month_length,
  output logic [hyml_pkg::YLEN_W-1:0]                           year_length,
  output logic [hyml_pkg::ELAPSED_W-1:0]                        new_year_elapsed
);

  localparam logic [hyml_pkg::MONTH_W-1:0] MON_IYYAR   = 4'd2;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_TAMMUZ  = 4'd4;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_ELUL    = 4'd6;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_HESHVAN = 4'd8;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_KISLEV  = 4'd9;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_TEVET   = 4'd10;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_ADAR    = 4'd12;
  localparam logic [hyml_pkg::MONTH_W-1:0] MON_ADAR_II = 4'd13;

  // Stage 6: lanes hold years Y-1, Y, Y+1, Y+2
  logic [hyml_pkg::DAYS_W-1:0]    d01, d12, d23;
  logic [1:0]                     x_here, x_next;
  logic [hyml_pkg::DAYS_W-1:0]    start_full, ylen_full;
  logic [hyml_pkg::ELAPSED_W-1:0] s6_start;
  logic [hyml_pkg::YLEN_W-1:0]    s6_ylen;
  hyml_pkg::hyml_side_t           s6_side;

  assign d01 = days[1] - days[0];
  assign d12 = days[2] - days[1];
  assign d23 = days[3] - days[2];

  always_comb begin
    if (d12 == 23'(hyml_pkg::LEN_POSTPONE2)) begin
      x_here = 2'd2;
    end else if (d01 == 23'(hyml_pkg::LEN_POSTPONE1)) begin
      x_here = 2'd1;
    end else begin
      x_here = 2'd0;
    end
    if (d23 == 23'(hyml_pkg::LEN_POSTPONE2)) begin
      x_next = 2'd2;
    end else if (d12 == 23'(hyml_pkg::LEN_POSTPONE1)) begin
      x_next = 2'd1;
    end else begin
      x_next = 2'd0;
    end
  end

  // Bias cancels in the difference; start is taken modulo 2^22.
  assign start_full = days[1] - 23'(hyml_pkg::DAY_BIAS) + 23'(x_here);
  assign ylen_full  = d12 + 23'(x_next) - 23'(x_here);

  always_ff @(posedge clk) begin
    if (ctl.fin_en[0]) begin
      s6_start <= start_full[hyml_pkg::ELAPSED_W-1:0];
      s6_ylen  <= ylen_full[hyml_pkg::YLEN_W-1:0];
      s6_side  <= side;
    end
  end

  // Stage 7: year length mod 10 and month length
  logic [16:0]                       q10_prod;
  logic [hyml_pkg::DIV10_Q_W-1:0]    q10;
  logic [hyml_pkg::YLEN_W-1:0]       rem_full;
  logic [3:0]                        ymod;
  logic [hyml_pkg::MLEN_W-1:0]       mlen;

  assign q10_prod = 17'(s6_ylen) * 17'(hyml_pkg::DIV10_MUL);
  assign q10      = q10_prod[hyml_pkg::DIV10_SHIFT +: hyml_pkg::DIV10_Q_W];
  assign rem_full = s6_ylen - 9'(9'(q10) * 9'd10);
  assign ymod     = rem_full[3:0];

  always_comb begin
    case (s6_side.month) inside
      MON_IYYAR, MON_TAMMUZ, MON_ELUL, MON_TEVET, MON_ADAR_II:
        mlen = hyml_pkg::DAYS_SHORT;
      MON_ADAR:
        mlen = s6_side.leap ? hyml_pkg::DAYS_FULL : hyml_pkg::DAYS_SHORT;
      MON_HESHVAN:
        mlen = (ymod == 4'd5) ? hyml_pkg::DAYS_FULL : hyml_pkg::DAYS_SHORT;
      MON_KISLEV:
        mlen = (ymod == 4'd3) ? hyml_pkg::DAYS_SHORT : hyml_pkg::DAYS_FULL;
      default:
        mlen = hyml_pkg::DAYS_FULL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_en[1]) begin
      leap_flag        <= s6_side.leap;
      months_in_year   <= s6_side.leap ? hyml_pkg::MONTHS_LEAP : hyml_pkg::MONTHS_COMMON;
      month_length     <= mlen;
      year_length      <= s6_ylen;
      new_year_elapsed <= s6_start;
    end
  end

endmodule

`default_nettype wire

// ===== src/hebrew_year_and_month_length_unit.sv =====
`default_nettype none

// Channel  Dir  Fields
// req      in   hebrew_year[13:0], month_number[3:0]
// rsp      out  leap_flag, months_in_year[3:0], month_length[4:0], year_length[8:0],
//               new_year_elapsed[21:0]
//
// One query per cycle unless an rsp stall has filled every stage. Each query
// passes through the five-stage molad lanes (one per year Y-1..Y+2) and then
// two finishing stages; the last stage is the rsp register.
// Synchronous reset clears the stage valid bits; data registers are not reset.
// During an rsp stall full stages hold and empty stages keep filling, so
// req stays ready until every stage is occupied.
module hebrew_year_and_month_length_unit (
  input  wire         clk,
  input  wire         rst,
  hyml_req_if.sink    req,
  hyml_rsp_if.source  rsp
);

  hyml_pkg::hyml_ctl_t ctl;
  logic [hyml_pkg::NUM_LANES-1:0][hyml_pkg::DAYS_W-1:0] lane_days;

  hyml_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  for (genvar j = 0; j < hyml_pkg::NUM_LANES; j++) begin : g_lane
    logic [hyml_pkg::LANE_Y_W-1:0] year_p1;

    // Lane j evaluates year Y-1+j, fed as that year plus one.
    assign year_p1 = hyml_pkg::LANE_Y_W'(req.hebrew_year) + hyml_pkg::LANE_Y_W'(j);

    hyml_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .year_p1 (year_p1),
      .days    (lane_days[j])
    );
  end

  // Leap flag: (7*Y + 1) mod 19 < 7, carried with the month beside the lanes.
  logic [hyml_pkg::LEAP_X_W-1:0]   lx;
  logic [hyml_pkg::LEAP_X_W+17:0]  l_prod;
  logic [hyml_pkg::Q19_W-1:0]      lq;
  logic [hyml_pkg::LEAP_X_W-1:0]   lrem;
  logic                            leap_now;
  hyml_pkg::hyml_side_t            side_p [hyml_pkg::LANE_STAGES];

  assign lx       = 17'(req.hebrew_year) * 17'(hyml_pkg::LEAP_STEP) + 17'd1;
  assign l_prod   = 35'(lx) * 35'(hyml_pkg::DIV19_MUL);
  assign lq       = l_prod[hyml_pkg::DIV19_SHIFT +: hyml_pkg::Q19_W];
  assign lrem     = lx - 17'(lq) * 17'(hyml_pkg::CYCLE_YEARS);
  assign leap_now = lrem < 17'(hyml_pkg::LEAP_STEP);

  always_ff @(posedge clk) begin
    if (ctl.lane_en[0]) begin
      side_p[0] <= '{leap: leap_now, month: req.month_number};
    end
    for (int k = 1; k < hyml_pkg::LANE_STAGES; k++) begin
      if (ctl.lane_en[k]) begin
        side_p[k] <= side_p[k-1];
      end
    end
  end

  hyml_finish u_finish (
    .clk              (clk),
    .ctl              (ctl),
    .days             (lane_days),
    .side             (side_p[hyml_pkg::LANE_STAGES-1]),
    .leap_flag        (rsp.leap_flag),
    .months_in_year   (rsp.months_in_year),
    .month_length     (rsp.month_length),
    .year_length      (rsp.year_length),
    .new_year_elapsed (rsp.new_year_elapsed)
  );

endmodule

`default_nettype wire

// ===== src/hyml_port_checker.sv =====
`default_nettype none

`include "hebrew_year_and_month_length_unit_assert.svh"

module hyml_port_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            req_ready,
  input wire                            rsp_valid,
  input wire                            rsp_ready,
  input wire                            leap_flag,
  input wire [hyml_pkg::MCOUNT_W-1:0]   months_in_year,
  input wire [hyml_pkg::MLEN_W-1:0]     month_length,
  input wire [hyml_pkg::YLEN_W-1:0]     year_length
);

  logic mcount_ok;
  logic ylen_ok;
  logic mlen_ok;

  assign mcount_ok = months_in_year ==
                     (leap_flag ? hyml_pkg::MONTHS_LEAP : hyml_pkg::MONTHS_COMMON);
  // Deficient, regular or complete, in a common or a leap year.
  assign ylen_ok   = (year_length >= 9'd353 && year_length <= 9'd355) ||
                     (year_length >= 9'd383 && year_length <= 9'd385);
  assign mlen_ok   = month_length == hyml_pkg::DAYS_SHORT ||
                     month_length == hyml_pkg::DAYS_FULL;

  `HYML_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

  // With the output register empty nothing can back up to the input.
  `HYML_ASSERT_IMPL(a_ready_when_drained, !rsp_valid, req_ready, "req stalled with empty output")

  `HYML_ASSERT_IMPL(a_month_count, rsp_valid, mcount_ok, "month count does not match leap flag")

  `HYML_ASSERT_IMPL(a_year_len, rsp_valid, ylen_ok, "year length out of set")

  `HYML_ASSERT_IMPL(a_month_len, rsp_valid, mlen_ok, "month length out of set")

endmodule

bind hebrew_year_and_month_length_unit hyml_port_checker u_port_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .leap_flag      (rsp.leap_flag),
  .months_in_year (rsp.months_in_year),
  .month_length   (rsp.month_length),
  .year_length    (rsp.year_length)
);

`default_nettype wire

// ===== tb/hyml_answer_checker.sv =====
`timescale 1ns / 1ps

module hyml_answer_checker
  import hyml_pkg::*;
(
  input  logic clk,
  input  logic rst,
  hyml_req_if  req,
  hyml_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   compared
);

  // Month numbers, counted from Nisan
  localparam logic [MONTH_W-1:0] IYYAR   = 4'd2;
  localparam logic [MONTH_W-1:0] TAMMUZ  = 4'd4;
  localparam logic [MONTH_W-1:0] ELUL    = 4'd6;
  localparam logic [MONTH_W-1:0] HESHVAN = 4'd8;
  localparam logic [MONTH_W-1:0] KISLEV  = 4'd9;
  localparam logic [MONTH_W-1:0] TEVET   = 4'd10;
  localparam logic [MONTH_W-1:0] ADAR_I  = 4'd12;
  localparam logic [MONTH_W-1:0] ADAR_II = 4'd13;

  // Molad arithmetic
  localparam longint CYCLE_MONTHS   = 235;
  localparam longint CYCLE_OFFSET   = 234;
  localparam longint CYCLE_LEN      = 19;
  localparam longint MOLAD_EPOCH    = 12084;
  localparam longint MONTH_PARTS    = 13753;
  localparam longint DAY_PARTS      = 25920;
  localparam longint LUNAR_DAYS     = 29;
  localparam longint SHORT_PREV_LEN = 356;
  localparam longint LONG_PREV_LEN  = 382;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic                 leap;
    logic [MCOUNT_W-1:0]  months;
    logic [MLEN_W-1:0]    mlen;
    logic [YLEN_W-1:0]    ylen;
    logic [ELAPSED_W-1:0] elapsed;
  } year_answer_t;

  year_answer_t answer_q[$];

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint floor_mod(longint a, longint b);
    longint r;
    r = a % b;
    if (r < 0) r = r + b;
    return r;
  endfunction

  // mean molad day, pushed one day on the unlucky weekdays
  function automatic longint molad_day(longint y);
    longint months, parts, days;
    months = floor_div(CYCLE_MONTHS * y - CYCLE_OFFSET, CYCLE_LEN);
    parts  = MOLAD_EPOCH + MONTH_PARTS * months;
    days   = LUNAR_DAYS * months + floor_div(parts, DAY_PARTS);
    if (floor_mod(3 * (days + 1), 7) < 3) days = days + 1;
    return days;
  endfunction

  function automatic longint new_year_day(longint y);
    longint prev, cur, nxt;
    prev = molad_day(y - 1);
    cur  = molad_day(y);
    nxt  = molad_day(y + 1);
    if (nxt - cur == SHORT_PREV_LEN) return cur + 2;
    if (cur - prev == LONG_PREV_LEN) return cur + 1;
    return cur;
  endfunction

  function automatic year_answer_t predict_answer(logic [YEAR_W-1:0] year,
                                                  logic [MONTH_W-1:0] month);
    year_answer_t a;
    longint y, start, ylen, ymod;
    logic leap;
    y     = longint'(year);
    leap  = floor_mod(7 * y + 1, CYCLE_LEN) < 7;
    start = new_year_day(y);
    ylen  = new_year_day(y + 1) - start;
    ymod  = floor_mod(ylen, 10);
    a.year   = year;
    a.month  = month;
    a.leap   = leap;
    a.months = leap ? MONTHS_LEAP : MONTHS_COMMON;
    case (month)
      IYYAR, TAMMUZ, ELUL, TEVET, ADAR_II: a.mlen = DAYS_SHORT;
      ADAR_I:  a.mlen = leap ? DAYS_FULL : DAYS_SHORT;
      HESHVAN: a.mlen = (ymod == 5) ? DAYS_FULL : DAYS_SHORT;
      KISLEV:  a.mlen = (ymod == 3) ? DAYS_SHORT : DAYS_FULL;
      default: a.mlen = DAYS_FULL;
    endcase
    a.ylen    = ylen[YLEN_W-1:0];
    a.elapsed = start[ELAPSED_W-1:0];
    return a;
  endfunction

  task automatic check_field(string name, year_answer_t want, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch (year %0d month %0d): expected %0d, actual %0d",
               $time, name, want.year, want.month, exp_v, act_v);
    end
  endtask

  // Counters are 2-state and start at zero; only this block writes them.
  always @(posedge clk) begin : watch
    year_answer_t want;
    if (rst) begin
      answer_q.delete();
    end else begin
      if (req.valid && req.ready)
        answer_q.push_back(predict_answer(req.hebrew_year, req.month_number));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, actual leap=%0d len=%0d elapsed=%0d",
                   $time, rsp.leap_flag, rsp.year_length, rsp.new_year_elapsed);
        end else begin
          want = answer_q.pop_front();
          compared++;
          check_field("leap_flag", want, want.leap, rsp.leap_flag);
          check_field("months_in_year", want, want.months, rsp.months_in_year);
          check_field("month_length", want, want.mlen, rsp.month_length);
          check_field("year_length", want, want.ylen, rsp.year_length);
          check_field("new_year_elapsed", want, want.elapsed, rsp.new_year_elapsed);
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hyml_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_AT     = 400;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_COMB, RX_TRICKLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  int   errors, pending, compared;
  int   burst_left, sent_directed, sent_random;

  hyml_req_if req_ch ();
  hyml_rsp_if rsp_ch ();

  hebrew_year_and_month_length_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  hyml_answer_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .errors   (errors),
    .pending  (pending),
    .compared (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: switches at random between stall patterns
  initial begin : receiver
    rx_mode_t mode;
    int       left, phase;
    mode  = RX_ALWAYS;
    left  = 0;
    phase = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 120);
      end else begin
        left--;
      end
      phase++;
      case (mode)
        RX_ALWAYS: rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        RX_COMB:   rsp_ch.ready <= (phase % 5) < 3;
        default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_query(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.hebrew_year  <= y;
    req_ch.month_number <= m;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        5:       gap = $urandom_range(8, 30);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    int                 sel;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.hebrew_year  = '0;
    req_ch.month_number = '0;
    burst_left          = 0;
    sent_directed       = 0;
    sent_random         = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // every month code, in and out of range, in a leap year
    for (int k = 0; k < 16; k++) begin
      send_query(14'd5784, MONTH_W'(k));
      sent_directed++;
    end
    // tiny years, field extremes, Adar II and Adar I in a common year
    send_query(14'd0, 4'd7);
    send_query(14'd1, 4'd13);
    send_query(14'd2, 4'd1);
    send_query(14'd9999, 4'd8);
    send_query(14'd9999, 4'd9);
    send_query(14'd16383, 4'd15);
    send_query(14'd16382, 4'd12);
    send_query(14'd5783, 4'd13);
    send_query(14'd5783, 4'd12);
    sent_directed += 9;
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6)       y = YEAR_W'($urandom_range(2, 9999));
      else if (sel < 8)  y = YEAR_W'($urandom_range(0, 16383));
      else if (sel == 8) y = YEAR_W'($urandom_range(0, 40));
      else               y = YEAR_W'($urandom_range(16300, 16383));
      if ($urandom_range(0, 7) == 0) m = MONTH_W'($urandom_range(0, 15));
      else                           m = MONTH_W'($urandom_range(1, 13));
      send_query(y, m);
      sent_random++;
      if (n == DRAIN_AT) drain_results();
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d directed and %0d random queries (years 0..16383, months 0..15),",
             sent_directed, sent_random);
    $display("compared %0d responses under random sender gaps and receiver stalls.",
             compared);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d responses outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== hebrew_year_and_month_length_unit.f =====
+incdir+src
src/hyml_pkg.sv
src/hyml_if.sv
src/hyml_ctrl.sv
src/hyml_lane.sv
src/hyml_finish.sv
src/hebrew_year_and_month_length_unit.sv
src/hyml_port_checker.sv
tb/hyml_answer_checker.sv
tb/tb.sv
